// ===== sv/tdss_pkg.sv =====
// Shared types and constants for the table-driven sensor sequencer.
package tdss_pkg;

    localparam int NUM_STATES      = 16;
    localparam int STATE_W         = $clog2(NUM_STATES);
    localparam int MAX_TRANSITIONS = 4;
    localparam int TRANS_W         = $clog2(MAX_TRANSITIONS);
    localparam int MAX_CONDITIONS  = 4;
    localparam int COND_W          = $clog2(MAX_CONDITIONS);
    localparam int COUNT_W         = 3;
    localparam int NUM_SENSORS     = 8;
    localparam int SENSOR_W        = $clog2(NUM_SENSORS);
    localparam int BLINK_W         = 8;
    localparam int BLINK_ON_W      = 10;
    localparam int HOLD_W          = 16;
    localparam int PAUSE_W         = 16;
    localparam int ELAPSED_W       = 32;
    localparam int PULSE_W         = BLINK_W + BLINK_ON_W + 1;
    localparam int PHASE_W         = 20;
    localparam int DIVISOR_W       = BLINK_ON_W + 1;

    localparam int TRN_DEPTH  = NUM_STATES * MAX_TRANSITIONS;
    localparam int TRN_ADDR_W = STATE_W + TRANS_W;
    localparam int CND_DEPTH  = TRN_DEPTH * MAX_CONDITIONS;
    localparam int CND_ADDR_W = TRN_ADDR_W + COND_W;

    localparam logic [HOLD_W-1:0]     HOLD_TIME_RESET = 16'd3000;
    localparam logic [BLINK_ON_W-1:0] BLINK_ON_RESET  = 10'd200;
    localparam logic [PAUSE_W-1:0]    PAUSE_RESET     = 16'd1500;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_HDR  = 2'd1,
        MODE_TRN  = 2'd2,
        MODE_CND  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SENSOR = 2'd0,
        KIND_TIME   = 2'd1,
        KIND_AUDIO  = 2'd2
    } cond_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HOLD  = 2'd0,
        CFG_BLINK = 2'd1,
        CFG_PAUSE = 2'd2
    } cfg_index_t;

    // Input beat payload, lowest field in the lowest bits.
    typedef struct packed {
        logic [5:0]          pad;
        logic [31:0]         entry_value;
        logic                sensor_level;
        logic [SENSOR_W-1:0] sensor_number;
        logic [1:0]          condition_kind;
        logic [COUNT_W-1:0]  entry_count;
        logic [COND_W-1:0]   condition_index;
        logic [TRANS_W-1:0]  transition_index;
        logic [STATE_W-1:0]  state_index;
        logic                reset_pressed;
        logic [NUM_SENSORS-1:0] sensors;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] trans_count;
        logic [BLINK_W-1:0] blink_count;
    } hdr_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cond_count;
        logic [STATE_W-1:0] target;
    } trn_entry_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [SENSOR_W-1:0]  sensor;
        logic                 level;
        logic [ELAPSED_W-1:0] duration;
    } cnd_entry_t;

    typedef struct packed {
        logic load;
        logic write;
        logic tick;
        logic walk_init;
        logic trn_next;
        logic cond_next;
        logic take;
        logic pulse;
        logic phase;
        logic led_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic forced;
        logic nt_zero;
        logic nc_zero;
        logic trans_last;
        logic cond_last;
        logic cond_met;
        logic led_done;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/tdss_led_unit.sv =====
// Bit-serial remainder unit that decides the LED level from the blink phase.
module tdss_led_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [tdss_pkg::PHASE_W-1:0]       phase,
    input  logic [tdss_pkg::PULSE_W-1:0]       pulse,
    input  logic [tdss_pkg::BLINK_ON_W-1:0]    blink_on,
    output logic                               done,
    output logic                               lit
);

    localparam int CNT_W = $clog2(tdss_pkg::PHASE_W + 1);

    logic                               busy_reg;
    logic                               done_reg;
    logic                               lit_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [tdss_pkg::PHASE_W-1:0]       shift_reg;
    logic [tdss_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [tdss_pkg::BLINK_ON_W-1:0]    half_reg;

    logic                               enable;
    logic [tdss_pkg::DIVISOR_W:0]       trial;
    logic [tdss_pkg::DIVISOR_W:0]       divisor;
    logic [tdss_pkg::DIVISOR_W-1:0]     rem_next;

    assign enable  = (blink_on != '0) &&
                     (phase < {{(tdss_pkg::PHASE_W - tdss_pkg::PULSE_W){1'b0}}, pulse});
    assign divisor = {1'b0, half_reg, 1'b0};
    assign trial   = {rem_reg, shift_reg[tdss_pkg::PHASE_W-1]};

    always_comb
    begin
        if (trial >= divisor)
        begin
            rem_next = tdss_pkg::DIVISOR_W'(trial - divisor);
        end
        else
        begin
            rem_next = trial[tdss_pkg::DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            lit_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= enable;
            done_reg <= !enable;
            lit_reg  <= 1'b0;
            cnt_reg  <= CNT_W'(tdss_pkg::PHASE_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                lit_reg  <= rem_next < {1'b0, half_reg};
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= phase;
            rem_reg   <= '0;
            half_reg  <= blink_on;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[tdss_pkg::PHASE_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign lit  = lit_reg;

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("led unit busy with zero step count");

endmodule

// ===== sv/tdss_datapath.sv =====
// Datapath: tables, timers, config registers, transition walk and output register.
module tdss_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tdss_pkg::cmd_t                      cmd,
    output tdss_pkg::sts_t                      sts,
    input  logic [tdss_pkg::IN_TDATA_W-1:0]     in_tdata,
    input  logic [1:0]                          in_tuser,
    input  logic                                cfg_valid,
    input  logic [tdss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tdss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                out_valid,
    output logic [tdss_pkg::OUT_TDATA_W-1:0]    out_tdata,
    input  logic                                out_tready
);

    tdss_pkg::item_t                         item_reg;
    tdss_pkg::mode_t                         mode_reg;
    logic [tdss_pkg::HOLD_W-1:0]             hold_time_reg;
    logic [tdss_pkg::BLINK_ON_W-1:0]         blink_on_reg;
    logic [tdss_pkg::PAUSE_W-1:0]            pause_reg;
    logic [tdss_pkg::STATE_W-1:0]            active_reg;
    logic [tdss_pkg::ELAPSED_W-1:0]          elapsed_reg;
    logic [tdss_pkg::HOLD_W-1:0]             hold_reg;
    logic [tdss_pkg::PHASE_W-1:0]            phase_reg;
    logic [tdss_pkg::PULSE_W-1:0]            pulse_reg;
    logic                                    changed_reg;
    logic [tdss_pkg::TRANS_W-1:0]            trn_idx_reg;
    logic [tdss_pkg::COND_W-1:0]             cnd_idx_reg;
    logic                                    out_valid_reg;
    logic [tdss_pkg::OUT_TDATA_W-1:0]        out_data_reg;
    tdss_pkg::hdr_t                          hdr_reg [tdss_pkg::NUM_STATES];
    tdss_pkg::trn_entry_t                    trn_mem [tdss_pkg::TRN_DEPTH];
    tdss_pkg::cnd_entry_t                    cnd_mem [tdss_pkg::CND_DEPTH];
    tdss_pkg::trn_entry_t                    trn_rdata_reg;
    tdss_pkg::cnd_entry_t                    cnd_rdata_reg;

    tdss_pkg::hdr_t                          hdr_cur;
    logic [tdss_pkg::ELAPSED_W-1:0]          elapsed_inc;
    logic [tdss_pkg::HOLD_W-1:0]             hold_inc;
    logic                                    forced;
    logic                                    cond_met;
    logic [tdss_pkg::COUNT_W-1:0]            trn_count_next;
    logic [tdss_pkg::COUNT_W-1:0]            cnd_count_next;
    logic [tdss_pkg::COUNT_W-1:0]            entry_count_sat;
    logic [tdss_pkg::BLINK_W-1:0]            blink_sat;
    logic [tdss_pkg::PULSE_W-2:0]            blink_prod;
    logic [tdss_pkg::PHASE_W:0]              phase_inc;
    logic [tdss_pkg::PHASE_W:0]              cycle_len;
    logic [tdss_pkg::TRN_ADDR_W-1:0]         trn_wr_addr;
    logic [tdss_pkg::CND_ADDR_W-1:0]         cnd_wr_addr;
    logic                                    led_done;
    logic                                    led_lit;

    assign hdr_cur     = hdr_reg[active_reg];
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign hold_inc    = !item_reg.reset_pressed ? '0 :
                         (hold_reg == '1) ? hold_reg : hold_reg + 1'b1;
    assign forced      = item_reg.reset_pressed && (hold_inc >= hold_time_reg);

    always_comb
    begin
        case (tdss_pkg::cond_kind_t'(cnd_rdata_reg.kind))
            tdss_pkg::KIND_SENSOR: cond_met = item_reg.sensors[cnd_rdata_reg.sensor]
                                              == cnd_rdata_reg.level;
            tdss_pkg::KIND_TIME:   cond_met = elapsed_reg >= cnd_rdata_reg.duration;
            default:               cond_met = 1'b1;
        endcase
    end

    assign trn_count_next  = tdss_pkg::COUNT_W'(trn_idx_reg) + 1'b1;
    assign cnd_count_next  = tdss_pkg::COUNT_W'(cnd_idx_reg) + 1'b1;
    assign entry_count_sat = (item_reg.entry_count > tdss_pkg::COUNT_W'(tdss_pkg::MAX_TRANSITIONS))
                             ? tdss_pkg::COUNT_W'(tdss_pkg::MAX_TRANSITIONS)
                             : item_reg.entry_count;
    assign blink_sat       = (item_reg.entry_value > 32'd255) ? '1
                             : item_reg.entry_value[tdss_pkg::BLINK_W-1:0];
    assign blink_prod      = (tdss_pkg::PULSE_W-1)'(hdr_cur.blink_count)
                             * (tdss_pkg::PULSE_W-1)'(blink_on_reg);
    assign phase_inc       = {1'b0, phase_reg} + 1'b1;
    assign cycle_len       = (tdss_pkg::PHASE_W+1)'(pulse_reg) + (tdss_pkg::PHASE_W+1)'(pause_reg);
    assign trn_wr_addr     = {item_reg.state_index, item_reg.transition_index};
    assign cnd_wr_addr     = {item_reg.state_index, item_reg.transition_index,
                              item_reg.condition_index};

    // conditions in use saturate at the slot count
    logic [tdss_pkg::COUNT_W-1:0] cond_count_sat;
    assign cond_count_sat = (item_reg.entry_count > tdss_pkg::COUNT_W'(tdss_pkg::MAX_CONDITIONS))
                            ? tdss_pkg::COUNT_W'(tdss_pkg::MAX_CONDITIONS)
                            : item_reg.entry_count;

    always_comb
    begin
        sts.forced     = forced;
        sts.nt_zero    = hdr_cur.trans_count == '0;
        sts.nc_zero    = trn_rdata_reg.cond_count == '0;
        sts.trans_last = trn_count_next == hdr_cur.trans_count;
        sts.cond_last  = cnd_count_next == trn_rdata_reg.cond_count;
        sts.cond_met   = cond_met;
        sts.led_done   = led_done;
        sts.out_free   = !out_valid_reg || out_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg <= tdss_pkg::HOLD_TIME_RESET;
            blink_on_reg  <= tdss_pkg::BLINK_ON_RESET;
            pause_reg     <= tdss_pkg::PAUSE_RESET;
        end
        else if (cfg_valid)
        begin
            case (tdss_pkg::cfg_index_t'(cfg_index))
                tdss_pkg::CFG_HOLD:  hold_time_reg <= cfg_data;
                tdss_pkg::CFG_BLINK: blink_on_reg  <= cfg_data[tdss_pkg::BLINK_ON_W-1:0];
                tdss_pkg::CFG_PAUSE: pause_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= tdss_pkg::MODE_TICK;
            active_reg    <= '0;
            elapsed_reg   <= '0;
            hold_reg      <= '0;
            phase_reg     <= '0;
            changed_reg   <= 1'b0;
            trn_idx_reg   <= '0;
            cnd_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < tdss_pkg::NUM_STATES; k++)
            begin
                hdr_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                mode_reg    <= tdss_pkg::mode_t'(in_tuser);
                changed_reg <= 1'b0;
            end
            if (cmd.write && (mode_reg == tdss_pkg::MODE_HDR))
            begin
                hdr_reg[item_reg.state_index] <= '{trans_count: entry_count_sat,
                                                   blink_count: blink_sat};
            end
            if (cmd.tick)
            begin
                if (forced)
                begin
                    active_reg  <= '0;
                    elapsed_reg <= '0;
                    hold_reg    <= '0;
                    phase_reg   <= '0;
                    changed_reg <= 1'b1;
                end
                else
                begin
                    elapsed_reg <= elapsed_inc;
                    hold_reg    <= hold_inc;
                end
            end
            if (cmd.walk_init)
            begin
                trn_idx_reg <= '0;
                cnd_idx_reg <= '0;
            end
            if (cmd.trn_next)
            begin
                trn_idx_reg <= trn_idx_reg + 1'b1;
                cnd_idx_reg <= '0;
            end
            if (cmd.cond_next)
            begin
                cnd_idx_reg <= cnd_idx_reg + 1'b1;
            end
            if (cmd.take)
            begin
                active_reg  <= trn_rdata_reg.target;
                elapsed_reg <= '0;
                phase_reg   <= '0;
                changed_reg <= 1'b1;
            end
            if (cmd.phase && (mode_reg == tdss_pkg::MODE_TICK) && !changed_reg)
            begin
                phase_reg <= (phase_inc >= cycle_len) ? '0 : phase_inc[tdss_pkg::PHASE_W-1:0];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= tdss_pkg::item_t'(in_tdata);
        end
        if (cmd.pulse)
        begin
            pulse_reg <= {blink_prod, 1'b0};
        end
        if (cmd.emit)
        begin
            out_data_reg <= {2'b00, changed_reg, led_lit, active_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && (mode_reg == tdss_pkg::MODE_TRN))
        begin
            trn_mem[trn_wr_addr] <= '{cond_count: cond_count_sat,
                                      target: item_reg.entry_value[tdss_pkg::STATE_W-1:0]};
        end
        trn_rdata_reg <= trn_mem[{active_reg, trn_idx_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && (mode_reg == tdss_pkg::MODE_CND))
        begin
            cnd_mem[cnd_wr_addr] <= '{kind: item_reg.condition_kind,
                                      sensor: item_reg.sensor_number,
                                      level: item_reg.sensor_level,
                                      duration: item_reg.entry_value};
        end
        cnd_rdata_reg <= cnd_mem[{active_reg, trn_idx_reg, cnd_idx_reg}];
    end

    tdss_led_unit u_led (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.led_start),
        .phase    (phase_reg),
        .pulse    (pulse_reg),
        .blink_on (blink_on_reg),
        .done     (led_done),
        .lit      (led_lit)
    );

    assign out_valid = out_valid_reg;
    assign out_tdata = out_data_reg;

    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (elapsed_reg == '0) && (phase_reg == '0) && changed_reg)
        else $error("taken transition did not clear timers");

    a_write_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> !changed_reg)
        else $error("table write flagged a state change");

endmodule

// ===== sv/tdss_controller.sv =====
// Controller state machine sequencing table writes, ticks and the transition walk.
module tdss_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_mode,
    output logic               in_ready,
    output tdss_pkg::cmd_t     cmd,
    input  tdss_pkg::sts_t     sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TICK,
        ST_T_READ,
        ST_T_CHECK,
        ST_C_READ,
        ST_C_CHECK,
        ST_PULSE,
        ST_PHASE,
        ST_LED_START,
        ST_LED_RUN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (tdss_pkg::mode_t'(in_mode) == tdss_pkg::MODE_TICK)
                                 ? ST_TICK : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_PULSE;
            end
            ST_TICK:
            begin
                cmd.tick      = 1'b1;
                cmd.walk_init = 1'b1;
                state_next    = (sts.forced || sts.nt_zero) ? ST_PULSE : ST_T_READ;
            end
            ST_T_READ:
            begin
                state_next = ST_T_CHECK;
            end
            ST_T_CHECK:
            begin
                if (sts.nc_zero)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_PULSE;
                end
                else
                begin
                    state_next = ST_C_READ;
                end
            end
            ST_C_READ:
            begin
                state_next = ST_C_CHECK;
            end
            ST_C_CHECK:
            begin
                if (!sts.cond_met)
                begin
                    if (sts.trans_last)
                    begin
                        state_next = ST_PULSE;
                    end
                    else
                    begin
                        cmd.trn_next = 1'b1;
                        state_next   = ST_T_READ;
                    end
                end
                else if (sts.cond_last)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_PULSE;
                end
                else
                begin
                    cmd.cond_next = 1'b1;
                    state_next    = ST_C_READ;
                end
            end
            ST_PULSE:
            begin
                cmd.pulse  = 1'b1;
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                cmd.phase  = 1'b1;
                state_next = ST_LED_START;
            end
            ST_LED_START:
            begin
                cmd.led_start = 1'b1;
                state_next    = ST_LED_RUN;
            end
            ST_LED_RUN:
            begin
                if (sts.led_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_cond_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_C_CHECK) |-> !sts.nc_zero)
        else $error("condition checked on a transition with no conditions");

endmodule

// ===== sv/table_driven_sensor_sequencer_core.sv =====
// Top level of the table-driven sensor sequencer.
// A beat on the input stream is either a one-millisecond tick (tuser 0) carrying sensor
// levels and the reset button, or a write of a state header, transition or condition
// (tuser 1, 2, 3); each beat yields exactly one output beat with the current state, LED
// level and a state-change flag. Items are handled one at a time. The bit-serial
// remainder unit derives the LED level from the blink phase; that unit is skipped when
// blink_on is zero or the phase lies past the pulses. Unless the reset hold forces state
// 0 or the state has no transitions, a tick walks the transitions and conditions of the
// active state in order. The transition and condition tables sit in single-read
// memories with registered outputs, so each visited entry passes through a read state
// and a check state. An output stall holds the controller in its done state until the
// output register is free. The input is taken again while a finished result still
// waits in the output register. Config writes are always ready and belong only in idle
// periods.
module table_driven_sensor_sequencer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sensors[7:0], reset_pressed[8], state_index[12:9], transition_index[14:13],
    // condition_index[16:15], entry_count[19:17], condition_kind[21:20],
    // sensor_number[24:22], sensor_level[25], entry_value[57:26], zero[63:58]
    input  logic [tdss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                           s_axis_tuser,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // current_state[3:0], led_on[4], state_changed[5], zero[7:6]
    output logic [tdss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tdss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tdss_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tdss_pkg::cmd_t cmd;
    tdss_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    tdss_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tdss_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_tdata  (m_axis_tdata),
        .out_tready (m_axis_tready)
    );

endmodule

// ===== verif/tb_table_driven_sensor_sequencer_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the table-driven sensor sequencer core.
module tb_table_driven_sensor_sequencer_core;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int DRAIN_CYCLES    = 100;
    localparam int MAX_REPORTS     = 40;
    localparam logic [tdss_pkg::CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic [1:0]                       KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [tdss_pkg::STATE_W-1:0] state;
        logic                         led;
        logic                         changed;
    } status_t;

    class sequencer_scoreboard;
        logic [tdss_pkg::HOLD_W-1:0]     hold_time;
        logic [tdss_pkg::BLINK_ON_W-1:0] blink_on;
        logic [tdss_pkg::PAUSE_W-1:0]    pause_len;
        logic [tdss_pkg::STATE_W-1:0]    active;
        logic [tdss_pkg::ELAPSED_W-1:0]  state_ms;
        logic [tdss_pkg::HOLD_W-1:0]     hold_ms;
        int unsigned                     phase_ms;
        tdss_pkg::hdr_t                  headers [tdss_pkg::NUM_STATES];
        tdss_pkg::trn_entry_t            trns [tdss_pkg::NUM_STATES][tdss_pkg::MAX_TRANSITIONS];
        tdss_pkg::cnd_entry_t            conds [tdss_pkg::NUM_STATES]
                                               [tdss_pkg::MAX_TRANSITIONS]
                                               [tdss_pkg::MAX_CONDITIONS];
        status_t                         due_status [$];
        int                              results_seen;
        int                              errors;

        function new();
            hold_time    = tdss_pkg::HOLD_TIME_RESET;
            blink_on     = tdss_pkg::BLINK_ON_RESET;
            pause_len    = tdss_pkg::PAUSE_RESET;
            active       = '0;
            state_ms     = '0;
            hold_ms      = '0;
            phase_ms     = 0;
            results_seen = 0;
            errors       = 0;
            foreach (headers[i])
                headers[i] = '0;
        endfunction

        function void set_reg(logic [tdss_pkg::CFG_INDEX_W-1:0] idx,
                              logic [tdss_pkg::CFG_DATA_W-1:0] value);
            case (tdss_pkg::cfg_index_t'(idx))
                tdss_pkg::CFG_HOLD:  hold_time = value;
                tdss_pkg::CFG_BLINK: blink_on  = value[tdss_pkg::BLINK_ON_W-1:0];
                tdss_pkg::CFG_PAUSE: pause_len = value;
                default:   ;
            endcase
        endfunction

        function int unsigned pulse_ms();
            int unsigned blinks;
            blinks = headers[active].blink_count;
            return blinks * 2 * blink_on;
        endfunction

        function logic led_level();
            int unsigned pulse;
            int unsigned blink_period;
            pulse        = pulse_ms();
            blink_period = 2 * blink_on;
            if (blink_on == 0 || phase_ms >= pulse)
                return 1'b0;
            return (phase_ms % blink_period) < blink_on;
        endfunction

        function bit cond_holds(tdss_pkg::cnd_entry_t c,
                                logic [tdss_pkg::NUM_SENSORS-1:0] sensors);
            case (c.kind)
                tdss_pkg::KIND_SENSOR: return sensors[c.sensor] == c.level;
                tdss_pkg::KIND_TIME:   return state_ms >= c.duration;
                default:               return 1'b1;
            endcase
        endfunction

        function bit take_transition(logic [tdss_pkg::NUM_SENSORS-1:0] sensors);
            tdss_pkg::trn_entry_t t;
            bit                   ok;
            for (int i = 0; i < headers[active].trans_count; i++)
            begin
                t  = trns[active][i];
                ok = 1'b1;
                for (int j = 0; j < t.cond_count && ok; j++)
                    ok = cond_holds(conds[active][i][j], sensors);
                if (ok)
                begin
                    active = t.target;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void accept_item(tdss_pkg::mode_t mode, tdss_pkg::item_t it);
            bit          moved;
            int unsigned cycle_len;
            int unsigned nxt;
            moved = 1'b0;
            case (mode)
                tdss_pkg::MODE_TICK:
                begin
                    if (state_ms != '1)
                        state_ms++;
                    if (it.reset_pressed)
                    begin
                        if (hold_ms != '1)
                            hold_ms++;
                        if (hold_ms >= hold_time)
                        begin
                            active  = '0;
                            hold_ms = '0;
                            moved   = 1'b1;
                        end
                    end
                    else
                        hold_ms = '0;
                    if (!moved)
                        moved = take_transition(it.sensors);
                    if (moved)
                    begin
                        state_ms = '0;
                        phase_ms = 0;
                    end
                    else
                    begin
                        cycle_len = pulse_ms() + pause_len;
                        nxt       = phase_ms + 1;
                        phase_ms  = (nxt >= cycle_len) ? 0 : nxt;
                    end
                end
                tdss_pkg::MODE_HDR:
                begin
                    headers[it.state_index].trans_count =
                        (it.entry_count > tdss_pkg::MAX_TRANSITIONS)
                        ? tdss_pkg::COUNT_W'(tdss_pkg::MAX_TRANSITIONS) : it.entry_count;
                    headers[it.state_index].blink_count =
                        (it.entry_value > 255) ? 8'd255 : it.entry_value[7:0];
                end
                tdss_pkg::MODE_TRN:
                begin
                    trns[it.state_index][it.transition_index].cond_count =
                        (it.entry_count > tdss_pkg::MAX_CONDITIONS)
                        ? tdss_pkg::COUNT_W'(tdss_pkg::MAX_CONDITIONS) : it.entry_count;
                    trns[it.state_index][it.transition_index].target =
                        it.entry_value[tdss_pkg::STATE_W-1:0];
                end
                default:
                    conds[it.state_index][it.transition_index][it.condition_index] =
                        '{kind: it.condition_kind, sensor: it.sensor_number,
                          level: it.sensor_level, duration: it.entry_value};
            endcase
            due_status.push_back('{state: active, led: led_level(), changed: moved});
        endfunction

        task report(string what);
            if (errors < MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task compare_status(logic [tdss_pkg::OUT_TDATA_W-1:0] data);
            status_t want;
            results_seen++;
            if (due_status.size() == 0)
            begin
                report($sformatf("output beat %0h with no item outstanding", data));
                return;
            end
            want = due_status.pop_front();
            if (data[3:0] !== want.state)
                report($sformatf("current_state %0h, want %0h", data[3:0], want.state));
            if (data[4] !== want.led)
                report($sformatf("led_on %b, want %b", data[4], want.led));
            if (data[5] !== want.changed)
                report($sformatf("state_changed %b, want %b", data[5], want.changed));
        endtask

        task close_out();
            if (due_status.size() != 0)
                report($sformatf("%0d results never arrived", due_status.size()));
        endtask
    endclass

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic [tdss_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]                       s_axis_tuser  = tdss_pkg::MODE_TICK;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [tdss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [tdss_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [tdss_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    sequencer_scoreboard sb;
    int cycles        = 0;
    int items_sent    = 0;
    int send_idle_pct = 27;
    int recv_idle_pct = 72;
    int press_left    = 0;
    bit trn_ready [tdss_pkg::NUM_STATES][tdss_pkg::MAX_TRANSITIONS];
    bit cnd_ready [tdss_pkg::NUM_STATES][tdss_pkg::MAX_TRANSITIONS][tdss_pkg::MAX_CONDITIONS];

    table_driven_sensor_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.accept_item(tdss_pkg::mode_t'(s_axis_tuser),
                               tdss_pkg::item_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.compare_status(m_axis_tdata);
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_beat(tdss_pkg::mode_t mode, tdss_pkg::item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        it.pad = '0;
        s_axis_tdata  <= it;
        s_axis_tuser  <= mode;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // table writes mark the slots they fill so that no walk reads an unwritten entry
    task automatic send_write(tdss_pkg::mode_t mode, tdss_pkg::item_t it);
        if (mode == tdss_pkg::MODE_TRN)
            trn_ready[it.state_index][it.transition_index] = 1'b1;
        if (mode == tdss_pkg::MODE_CND)
            cnd_ready[it.state_index][it.transition_index][it.condition_index] = 1'b1;
        send_beat(mode, it);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.results_seen < items_sent)
            @(posedge clk);
    endtask

    task automatic load_registers(logic [tdss_pkg::CFG_DATA_W-1:0] hold,
                                  logic [tdss_pkg::CFG_DATA_W-1:0] blink,
                                  logic [tdss_pkg::CFG_DATA_W-1:0] pause);
        logic [tdss_pkg::CFG_INDEX_W-1:0] idx [4];
        logic [tdss_pkg::CFG_DATA_W-1:0]  val [4];
        idx = '{tdss_pkg::CFG_HOLD, tdss_pkg::CFG_BLINK, tdss_pkg::CFG_PAUSE, CFG_SPARE};
        val = '{hold, blink, pause, tdss_pkg::CFG_DATA_W'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic tdss_pkg::item_t random_item();
        tdss_pkg::item_t it;
        it     = tdss_pkg::item_t'({$urandom, $urandom});
        it.pad = '0;
        return it;
    endfunction

    function automatic tdss_pkg::item_t make_write(int s, int t, int c, int cnt,
                                                   logic [1:0] kind, int sn, logic lvl,
                                                   logic [31:0] value);
        tdss_pkg::item_t it;
        it                  = '0;
        it.state_index      = tdss_pkg::STATE_W'(s);
        it.transition_index = tdss_pkg::TRANS_W'(t);
        it.condition_index  = tdss_pkg::COND_W'(c);
        it.entry_count      = tdss_pkg::COUNT_W'(cnt);
        it.condition_kind   = kind;
        it.sensor_number    = tdss_pkg::SENSOR_W'(sn);
        it.sensor_level     = lvl;
        it.entry_value      = value;
        return it;
    endfunction

    function automatic tdss_pkg::item_t make_tick(logic [tdss_pkg::NUM_SENSORS-1:0] sensors,
                                                  logic pressed);
        tdss_pkg::item_t it;
        it               = '0;
        it.sensors       = sensors;
        it.reset_pressed = pressed;
        return it;
    endfunction

    function automatic int random_count();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
    endfunction

    function automatic int pick_state();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return int'(sb.active);
        if (roll < 9)
            return $urandom_range(0, 5);
        return $urandom_range(0, tdss_pkg::NUM_STATES - 1);
    endfunction

    task automatic put_condition(int s, int t, int c);
        tdss_pkg::item_t it;
        int              roll;
        it                  = random_item();
        it.state_index      = tdss_pkg::STATE_W'(s);
        it.transition_index = tdss_pkg::TRANS_W'(t);
        it.condition_index  = tdss_pkg::COND_W'(c);
        roll = $urandom_range(0, 9);
        if (roll < 4)
            it.condition_kind = tdss_pkg::KIND_SENSOR;
        else if (roll < 8)
            it.condition_kind = tdss_pkg::KIND_TIME;
        else if (roll == 8)
            it.condition_kind = tdss_pkg::KIND_AUDIO;
        else
            it.condition_kind = KIND_SPARE;
        if ($urandom_range(0, 9) != 0)
            it.entry_value = $urandom_range(0, 30);
        send_write(tdss_pkg::MODE_CND, it);
    endtask

    task automatic put_transition(int s, int t, int cnt);
        tdss_pkg::item_t it;
        int              used;
        used = (cnt > tdss_pkg::MAX_CONDITIONS) ? tdss_pkg::MAX_CONDITIONS : cnt;
        for (int c = 0; c < used; c++)
            if (!cnd_ready[s][t][c])
                put_condition(s, t, c);
        it                  = random_item();
        it.state_index      = tdss_pkg::STATE_W'(s);
        it.transition_index = tdss_pkg::TRANS_W'(t);
        it.entry_count      = tdss_pkg::COUNT_W'(cnt);
        if ($urandom_range(0, 3) != 0)
            it.entry_value = $urandom_range(0, 5);
        send_write(tdss_pkg::MODE_TRN, it);
    endtask

    task automatic put_header(int s, int cnt);
        tdss_pkg::item_t it;
        int              used;
        used = (cnt > tdss_pkg::MAX_TRANSITIONS) ? tdss_pkg::MAX_TRANSITIONS : cnt;
        for (int t = 0; t < used; t++)
            if (!trn_ready[s][t])
                put_transition(s, t, random_count());
        it             = random_item();
        it.state_index = tdss_pkg::STATE_W'(s);
        it.entry_count = tdss_pkg::COUNT_W'(cnt);
        case ($urandom_range(0, 9))
            0:       it.entry_value = 255;
            1:       it.entry_value = $urandom;
            default: it.entry_value = $urandom_range(0, 3);
        endcase
        send_write(tdss_pkg::MODE_HDR, it);
    endtask

    // button presses come in runs so that the hold timer can reach its limit
    task automatic put_tick();
        tdss_pkg::item_t it;
        it = random_item();
        if (press_left == 0 && $urandom_range(0, 29) == 0)
            press_left = $urandom_range(1, 8);
        it.reset_pressed = (press_left != 0) || ($urandom_range(0, 49) == 0);
        if (press_left != 0)
            press_left--;
        send_beat(tdss_pkg::MODE_TICK, it);
    endtask

    task automatic run_directed();
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'h00, 1'b0));
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'hFF, 1'b1));
        send_write(tdss_pkg::MODE_CND,
                   make_write(0, 0, 0, 0, tdss_pkg::KIND_SENSOR, 7, 1'b1, 32'hFFFF_FFFF));
        send_write(tdss_pkg::MODE_CND,
                   make_write(0, 0, 1, 0, KIND_SPARE, 0, 1'b0, 32'd0));
        send_write(tdss_pkg::MODE_TRN,
                   make_write(0, 0, 0, 2, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'hFFFF_FFF5));
        send_write(tdss_pkg::MODE_CND,
                   make_write(5, 0, 0, 0, tdss_pkg::KIND_TIME, 0, 1'b0, 32'd2));
        send_write(tdss_pkg::MODE_CND,
                   make_write(5, 0, 1, 0, tdss_pkg::KIND_AUDIO, 0, 1'b0, 32'd0));
        send_write(tdss_pkg::MODE_CND,
                   make_write(5, 0, 2, 0, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd0));
        send_write(tdss_pkg::MODE_CND,
                   make_write(5, 0, 3, 0, tdss_pkg::KIND_TIME, 0, 1'b0, 32'd0));
        send_write(tdss_pkg::MODE_TRN,
                   make_write(5, 0, 0, 7, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd10));
        send_write(tdss_pkg::MODE_TRN,
                   make_write(5, 1, 0, 0, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd5));
        send_write(tdss_pkg::MODE_HDR,
                   make_write(5, 0, 0, 2, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd1000));
        send_write(tdss_pkg::MODE_HDR,
                   make_write(0, 0, 0, 1, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd0));
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'h00, 1'b0));
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'h80, 1'b0));
        // state 5: timed condition not yet met, second transition loops back to itself
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'h00, 1'b0));
        send_write(tdss_pkg::MODE_HDR,
                   make_write(15, 0, 0, 0, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd255));
        send_write(tdss_pkg::MODE_CND,
                   make_write(15, 3, 3, 0, KIND_SPARE, 7, 1'b1, 32'hFFFF_FFFF));
        send_write(tdss_pkg::MODE_TRN,
                   make_write(15, 3, 0, 0, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd0));
        send_write(tdss_pkg::MODE_HDR,
                   make_write(5, 0, 0, 1, tdss_pkg::KIND_SENSOR, 0, 1'b0, 32'd3));
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'h01, 1'b0));
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'h00, 1'b1));
        send_beat(tdss_pkg::MODE_TICK, make_tick(8'hFF, 1'b1));
    endtask

    task automatic run_random(int count, bit hold_off);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            if (hold_off && n == count / 2)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 70)
                put_tick();
            else if (roll < 80)
                put_header(pick_state(), random_count());
            else if (roll < 90)
                put_transition(pick_state(), $urandom_range(0, 3), random_count());
            else
                put_condition(pick_state(), $urandom_range(0, 3), $urandom_range(0, 3));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 27;
            end
            if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0:       load_registers(16'd0, 16'd0, 16'd0);
                1:       load_registers(16'hFFFF, 16'h03FF, 16'hFFFF);
                2:       load_registers(16'd1, 16'd1, 16'd0);
                3:       load_registers(16'd2, 16'd3, 16'd5);
                4:       load_registers(16'd4, 16'd2, 16'd1);
                default: load_registers(tdss_pkg::CFG_DATA_W'($urandom_range(1, 6)),
                                        tdss_pkg::CFG_DATA_W'($urandom_range(1, 4)),
                                        tdss_pkg::CFG_DATA_W'($urandom_range(0, 10)));
            endcase
            run_random(ITEMS_PER_PHASE, p == 3);
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
